@@ hdl/fps_pkg.sv @@
// shared types and constants for the fir filter with peak statistics
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int OUT_BITS   = 38;
  localparam int PEAK_BITS  = 52;
  localparam int COUNT_BITS = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 8'd255;
  localparam logic [COUNT_BITS-1:0] TAPS_RESET = 8'd101;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_SAT,
    ST_UPDATE,
    ST_REPLY
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic issue;
    logic use_tap;
  } mac_ctrl_t;

  typedef struct packed {
    logic clear;
    logic update;
  } stats_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/fps_cell.sv @@
// one history cell of the sample chain
`timescale 1ns / 1ps
`default_nettype none

module fps_cell import fps_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [WIDTH-1:0] left,
  input  logic [WIDTH-1:0] right,
  output logic [WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_SHIFT:  data <= left;
      CELL_ROTATE: data <= right;
      CELL_HOLD:   data <= data;
      default:     data <= data;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/fps_mac.sv @@
// tap memory and shared multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none

module fps_mac import fps_pkg::*; #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16,
  localparam int IDX_W      = $clog2(MAX_TAPS),
  localparam int ACC_W      = 2 * SAMPLE_BITS + IDX_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_ctrl_t                     ctrl,
  input  logic        [IDX_W-1:0]       load_index,
  input  logic signed [SAMPLE_BITS-1:0] load_value,
  input  logic        [IDX_W-1:0]       read_index,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [ACC_W-1:0]       acc
);

  logic signed [SAMPLE_BITS-1:0]   taps [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]   tap_rd;
  logic signed [SAMPLE_BITS-1:0]   sample_rd;
  logic signed [2*SAMPLE_BITS-1:0] product;
  logic                            rd_use;
  logic                            product_use;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      taps[load_index] <= load_value;
    end
    if (ctrl.issue) begin
      tap_rd    <= taps[read_index];
      sample_rd <= sample;
    end
    product <= tap_rd * sample_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_use      <= 1'b0;
      product_use <= 1'b0;
      acc         <= '0;
    end else begin
      rd_use      <= ctrl.issue && ctrl.use_tap;
      product_use <= rd_use;
      if (ctrl.clear) begin
        acc <= '0;
      end else if (product_use) begin
        acc <= acc + ACC_W'(product);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/fps_stats.sv @@
// running min, max and saturating local peak sum
`timescale 1ns / 1ps
`default_nettype none

module fps_stats import fps_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  stats_ctrl_t                 ctrl,
  input  logic signed [OUT_BITS-1:0]  value,
  output logic signed [OUT_BITS-1:0]  min_seen,
  output logic signed [OUT_BITS-1:0]  max_seen,
  output logic signed [PEAK_BITS-1:0] peak_total
);

  localparam logic signed [PEAK_BITS:0] PEAK_HI = {2'b00, {(PEAK_BITS-1){1'b1}}};
  localparam logic signed [PEAK_BITS:0] PEAK_LO = {2'b11, {(PEAK_BITS-1){1'b0}}};

  logic signed [OUT_BITS-1:0]  older;
  logic signed [OUT_BITS-1:0]  pending;
  logic                        pending_valid;
  logic signed [PEAK_BITS:0]   peak_wide;
  logic signed [PEAK_BITS-1:0] peak_next;
  logic                        is_peak;

  assign peak_wide = (PEAK_BITS+1)'(peak_total) + (PEAK_BITS+1)'(pending);
  assign is_peak   = pending_valid && (pending >= older) && (pending >= value);

  always_comb begin
    if (peak_wide > PEAK_HI) begin
      peak_next = PEAK_HI[PEAK_BITS-1:0];
    end else if (peak_wide < PEAK_LO) begin
      peak_next = PEAK_LO[PEAK_BITS-1:0];
    end else begin
      peak_next = peak_wide[PEAK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      min_seen      <= '0;
      max_seen      <= '0;
      peak_total    <= '0;
      older         <= '0;
      pending       <= '0;
      pending_valid <= 1'b0;
    end else if (ctrl.update) begin
      if (value < min_seen) min_seen <= value;
      if (value > max_seen) max_seen <= value;
      if (is_peak) peak_total <= peak_next;
      older         <= pending_valid ? pending : '0;
      pending       <= value;
      pending_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fir_filter_with_peak_stats.sv @@
// top level: fir filter over a rotating sample chain with output statistics
// a push that fills the window has the shared multiply-accumulate walk the whole chain
// once, one cell a cycle, then steps through drain1, drain2, sat, update and reply
// a new word is taken only in idle; load, clear and short pushes go straight to reply;
// the result of a replied word waits in the output register while the next is taken
// reset: synchronous, clears control, count and statistics, window length back to 101
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_with_peak_stats import fps_pkg::*; #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic        [COUNT_BITS-1:0]  write_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic        [1:0]             operation,
  input  logic        [6:0]             tap_index,
  input  logic signed [SAMPLE_BITS-1:0] coefficient,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [OUT_BITS-1:0]    filtered,
  output logic                          filtered_valid,
  output logic signed [OUT_BITS-1:0]    running_min,
  output logic signed [OUT_BITS-1:0]    running_max,
  output logic signed [PEAK_BITS-1:0]   peak_sum
);

  localparam int IDX_W   = $clog2(MAX_TAPS);
  localparam int ACC_W   = 2 * SAMPLE_BITS + IDX_W + 1;
  localparam int SAT_W   = (ACC_W > OUT_BITS) ? ACC_W : OUT_BITS;
  localparam int TAP_CAP = (MAX_TAPS < 255) ? MAX_TAPS : 255;
  localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_TAPS - 1);
  localparam logic signed [SAT_W-1:0] OUT_HI =
    {{(SAT_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OUT_LO =
    {{(SAT_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

  fsm_state_t state, state_next;
  op_t        item_op;
  cell_op_t   cell_op;
  mac_ctrl_t  mac_ctrl;
  stats_ctrl_t stats_ctrl;

  logic [COUNT_BITS-1:0] taps_in_use;
  logic [COUNT_BITS-1:0] taps_eff;
  logic [COUNT_BITS-1:0] samples_seen;
  logic [COUNT_BITS-1:0] seen_next;
  logic [IDX_W-1:0]      step;
  logic                  accept;
  logic                  window_full;
  logic                  idx_ok;
  logic                  step_in_use;
  logic                  reply_load;

  logic [SAMPLE_BITS-1:0] cell_q   [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] left_in  [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] right_in [MAX_TAPS];

  logic signed [ACC_W-1:0]     acc;
  logic signed [SAT_W-1:0]     acc_x;
  logic signed [OUT_BITS-1:0]  acc_sat;
  logic signed [OUT_BITS-1:0]  filtered_hold;
  logic                        valid_hold;
  logic signed [OUT_BITS-1:0]  stat_min;
  logic signed [OUT_BITS-1:0]  stat_max;
  logic signed [PEAK_BITS-1:0] stat_peak;

  assign item_op     = op_t'(operation);
  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign seen_next   = (samples_seen == COUNT_MAX) ? samples_seen : samples_seen + 1'b1;
  assign window_full = (seen_next >= taps_eff);
  assign idx_ok      = (32'(tap_index) < MAX_TAPS);
  assign step_in_use = (32'(step) < 32'(taps_eff));

  always_comb begin
    taps_eff = taps_in_use;
    if (taps_in_use == '0) begin
      taps_eff = 8'd1;
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      taps_eff = TAP_CAP[COUNT_BITS-1:0];
    end
  end

  // sample chain
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign left_in[i] = sample;
    end else begin : g_body
      assign left_in[i] = cell_q[i-1];
    end
    if (i == MAX_TAPS - 1) begin : g_wrap
      assign right_in[i] = cell_q[0];
    end else begin : g_next
      assign right_in[i] = cell_q[i+1];
    end
    fps_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .left  (left_in[i]),
      .right (right_in[i]),
      .data  (cell_q[i])
    );
  end

  fps_mac #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .load_index (IDX_W'(tap_index)),
    .load_value (coefficient),
    .read_index (step),
    .sample     (cell_q[0]),
    .acc        (acc)
  );

  fps_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (stats_ctrl),
    .value      (filtered_hold),
    .min_seen   (stat_min),
    .max_seen   (stat_max),
    .peak_total (stat_peak)
  );

  // saturate to output range
  assign acc_x = SAT_W'(acc);
  always_comb begin
    if (acc_x > OUT_HI) begin
      acc_sat = OUT_HI[OUT_BITS-1:0];
    end else if (acc_x < OUT_LO) begin
      acc_sat = OUT_LO[OUT_BITS-1:0];
    end else begin
      acc_sat = acc_x[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    stats_ctrl = '0;
    cell_op    = CELL_HOLD;
    reply_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item_op)
            OP_LOAD: begin
              mac_ctrl.load = idx_ok;
              state_next    = ST_REPLY;
            end
            OP_PUSH: begin
              cell_op = CELL_SHIFT;
              if (window_full) begin
                mac_ctrl.clear = 1'b1;
                state_next     = ST_WALK;
              end else begin
                state_next = ST_REPLY;
              end
            end
            OP_CLEAR: begin
              stats_ctrl.clear = 1'b1;
              state_next       = ST_REPLY;
            end
            default: state_next = ST_REPLY;
          endcase
        end
      end
      ST_WALK: begin
        cell_op          = CELL_ROTATE;
        mac_ctrl.issue   = 1'b1;
        mac_ctrl.use_tap = step_in_use;
        if (step == STEP_LAST) state_next = ST_DRAIN1;
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_SAT;
      ST_SAT:    state_next = ST_UPDATE;
      ST_UPDATE: begin
        stats_ctrl.update = 1'b1;
        state_next        = ST_REPLY;
      end
      ST_REPLY: begin
        if (!result_valid || !result_stall) begin
          reply_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use  <= TAPS_RESET;
      samples_seen <= '0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (write_enable) taps_in_use <= write_data;
      if (stats_ctrl.clear) begin
        samples_seen <= '0;
      end else if (cell_op == CELL_SHIFT) begin
        samples_seen <= seen_next;
      end
      if (state == ST_WALK) begin
        step <= (step == STEP_LAST) ? '0 : step + 1'b1;
      end
      if (reply_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      filtered_hold <= '0;
      valid_hold    <= 1'b0;
    end else if (state == ST_SAT) begin
      filtered_hold <= acc_sat;
      valid_hold    <= 1'b1;
    end
    if (reply_load) begin
      filtered       <= filtered_hold;
      filtered_valid <= valid_hold;
      running_min    <= stat_min;
      running_max    <= stat_max;
      peak_sum       <= stat_peak;
    end
  end

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && step == STEP_LAST) |=> (state == ST_DRAIN1))
    else $error("chain walk did not end after the last cell");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (samples_seen == $past(samples_seen)))
    else $error("sample count moved while busy");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && filtered_valid) |->
      (running_min <= filtered && running_max >= filtered))
    else $error("valid word outside running min and max");

  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (running_min <= 0 && running_max >= 0))
    else $error("running min or max crossed zero");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !filtered_valid) |-> (filtered == '0))
    else $error("invalid word carries a nonzero value");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for fir_filter_with_peak_stats: queued words, predicted outputs, field checks
`timescale 1ns / 1ps

module tb;
  import fps_pkg::*;

  localparam int MAX_TAPS    = 128;
  localparam int SAMPLE_BITS = 16;

  typedef struct {
    op_t                          op;
    logic [6:0]                   idx;
    logic signed [SAMPLE_BITS-1:0] coef;
    logic signed [SAMPLE_BITS-1:0] smp;
  } fir_word_t;

  typedef struct {
    logic signed [OUT_BITS-1:0]  filtered;
    logic                        filtered_valid;
    logic signed [OUT_BITS-1:0]  running_min;
    logic signed [OUT_BITS-1:0]  running_max;
    logic signed [PEAK_BITS-1:0] peak_sum;
  } fir_out_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          write_enable = 1'b0;
  logic [COUNT_BITS-1:0]         write_data = '0;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic [1:0]                    operation = '0;
  logic [6:0]                    tap_index = '0;
  logic signed [SAMPLE_BITS-1:0] coefficient = '0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic signed [OUT_BITS-1:0]    filtered;
  logic                          filtered_valid;
  logic signed [OUT_BITS-1:0]    running_min;
  logic signed [OUT_BITS-1:0]    running_max;
  logic signed [PEAK_BITS-1:0]   peak_sum;

  fir_filter_with_peak_stats #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_data     (write_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .tap_index      (tap_index),
    .coefficient    (coefficient),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .filtered       (filtered),
    .filtered_valid (filtered_valid),
    .running_min    (running_min),
    .running_max    (running_max),
    .peak_sum       (peak_sum)
  );

  fir_word_t word_queue[$];
  fir_out_t  fir_expected[$];
  fir_word_t cur_word;
  int        words_queued = 0;
  int        words_taken = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        calm_send = 1'b0;
  bit        calm_recv = 1'b0;
  bit        failed = 1'b0;

  // filter state mirror
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS] = '{default: '0};
  int                            hist_head = 0;
  int                            seen = 0;
  longint                        older_out = 0;
  longint                        held_out = 0;
  bit                            held_ok = 1'b0;
  longint                        lo_seen = 0;
  longint                        hi_seen = 0;
  longint                        peak_acc = 0;
  logic [COUNT_BITS-1:0]         window_len = TAPS_RESET;

  // generator view of the taps
  bit                    gen_loaded [MAX_TAPS] = '{default: 1'b0};
  logic [COUNT_BITS-1:0] gen_window = TAPS_RESET;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int eff_window(input logic [COUNT_BITS-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_TAPS) return MAX_TAPS;
    return int'(w);
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic fir_out_t fir_next(input fir_word_t w);
    fir_out_t o;
    longint   acc;
    longint   f;
    int       taps;
    int       j;
    o.filtered = '0;
    o.filtered_valid = 1'b0;
    case (w.op)
      OP_LOAD: coef_mem[w.idx] = w.coef;
      OP_PUSH: begin
        taps = eff_window(window_len);
        hist_head = (hist_head + 1) % MAX_TAPS;
        hist[hist_head] = w.smp;
        if (seen < COUNT_MAX) seen++;
        if (seen >= taps) begin
          acc = 0;
          for (j = 0; j < taps; j++)
            acc += longint'(hist[(hist_head + MAX_TAPS - j) % MAX_TAPS]) * longint'(coef_mem[j]);
          f = clip(acc, OUT_BITS);
          o.filtered = f[OUT_BITS-1:0];
          o.filtered_valid = 1'b1;
          if (f < lo_seen) lo_seen = f;
          if (f > hi_seen) hi_seen = f;
          // held output is a peak when no lower than its neighbors
          if (held_ok && held_out >= older_out && held_out >= f)
            peak_acc = clip(peak_acc + held_out, PEAK_BITS);
          older_out = held_ok ? held_out : 0;
          held_out = f;
          held_ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        hist = '{default: '0};
        hist_head = 0;
        seen = 0;
        older_out = 0;
        held_out = 0;
        held_ok = 1'b0;
        lo_seen = 0;
        hi_seen = 0;
        peak_acc = 0;
      end
      default: ;
    endcase
    o.running_min = lo_seen[OUT_BITS-1:0];
    o.running_max = hi_seen[OUT_BITS-1:0];
    o.peak_sum = peak_acc[PEAK_BITS-1:0];
    return o;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        fir_expected.push_back(fir_next(cur_word));
        words_taken++;
        if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
        send_gap = draw_wait(calm_send);
      end else if (send_gap != 0) begin
        send_gap--;
      end
      if (send_gap == 0 && word_queue.size() != 0) begin
        cur_word = word_queue.pop_front();
        operation <= cur_word.op;
        tap_index <= cur_word.idx;
        coefficient <= cur_word.coef;
        sample <= cur_word.smp;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    fir_out_t want;
    int       n;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (result_valid && !result_stall) begin
      if (fir_expected.size() == 0) begin
        $display("%0t unexpected word filtered %0d", $time, filtered);
        failed = 1'b1;
      end else begin
        want = fir_expected.pop_front();
        if (filtered !== want.filtered) begin
          $display("%0t filtered expected %0d actual %0d", $time, want.filtered, filtered);
          failed = 1'b1;
        end
        if (filtered_valid !== want.filtered_valid) begin
          $display("%0t filtered_valid expected %0d actual %0d", $time,
                   want.filtered_valid, filtered_valid);
          failed = 1'b1;
        end
        if (running_min !== want.running_min) begin
          $display("%0t running_min expected %0d actual %0d", $time,
                   want.running_min, running_min);
          failed = 1'b1;
        end
        if (running_max !== want.running_max) begin
          $display("%0t running_max expected %0d actual %0d", $time,
                   want.running_max, running_max);
          failed = 1'b1;
        end
        if (peak_sum !== want.peak_sum) begin
          $display("%0t peak_sum expected %0d actual %0d", $time, want.peak_sum, peak_sum);
          failed = 1'b1;
        end
      end
      if ($urandom_range(0, 39) == 0) calm_recv = !calm_recv;
      n = draw_wait(calm_recv);
      stall_left = n;
      result_stall <= (n != 0);
    end else if (stall_left != 0) begin
      result_stall <= (stall_left > 1);
      stall_left--;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_q15();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic void add_word(input op_t op, input logic [6:0] idx,
                                   input logic signed [SAMPLE_BITS-1:0] coef,
                                   input logic signed [SAMPLE_BITS-1:0] smp);
    fir_word_t w;
    w.op = op;
    w.idx = idx;
    w.coef = coef;
    w.smp = smp;
    if (op == OP_LOAD) gen_loaded[idx] = 1'b1;
    word_queue.push_back(w);
    words_queued++;
  endfunction

  // never push through a tap that was not loaded
  function automatic void add_push(input logic signed [SAMPLE_BITS-1:0] smp);
    int j;
    for (j = 0; j < eff_window(gen_window); j++)
      if (!gen_loaded[j]) add_word(OP_LOAD, 7'(j), rand_q15(), rand_q15());
    add_word(OP_PUSH, 7'($urandom), rand_q15(), smp);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (words_taken != words_queued || fir_expected.size() != 0);
  endtask

  task automatic set_window(input logic [COUNT_BITS-1:0] len);
    wait_idle();
    @(posedge clk);
    write_enable <= 1'b1;
    write_data <= len;
    @(posedge clk);
    write_enable <= 1'b0;
    window_len = len;
    gen_window = len;
  endtask

  task automatic rand_phase(input int count);
    int i;
    int r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 66) add_push(rand_q15());
      else if (r < 86) add_word(OP_LOAD, 7'($urandom), rand_q15(), rand_q15());
      else if (r < 89) add_word(OP_CLEAR, 7'($urandom), rand_q15(), rand_q15());
      else add_word(OP_NONE, 7'($urandom), rand_q15(), rand_q15());
    end
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // short window, directed corners
    set_window(8'd0);
    add_word(OP_NONE, 7'($urandom), rand_q15(), rand_q15());
    add_word(OP_LOAD, 7'd0, 16'sh8000, rand_q15());
    add_push(16'sh8000);
    add_push(16'sh7fff);
    add_push(16'sh0000);
    add_push(16'sh7fff);
    add_push(16'sh7fff);
    add_push(-16'sd1);
    add_word(OP_LOAD, 7'd127, 16'sh7fff, rand_q15());
    add_word(OP_LOAD, 7'd0, 16'sh7fff, rand_q15());
    add_push(16'sh8000);
    add_push(16'sh7fff);
    add_word(OP_CLEAR, 7'($urandom), rand_q15(), rand_q15());
    add_push(16'sd100);
    add_word(OP_NONE, 7'($urandom), rand_q15(), rand_q15());
    set_window(8'd1);
    add_push(16'sd5);
    add_push(-16'sd5);
    set_window(8'd3);
    for (i = 0; i < 5; i++) add_push(rand_q15());
    add_word(OP_CLEAR, 7'($urandom), rand_q15(), rand_q15());

    // full window of largest products saturates the sum
    set_window(8'd128);
    for (i = 0; i < MAX_TAPS; i++) add_word(OP_LOAD, 7'(i), 16'sh8000, rand_q15());
    for (i = 0; i < 140; i++) add_push(16'sh8000);
    for (i = 0; i < 130; i++) add_push(rand_q15());
    add_word(OP_CLEAR, 7'($urandom), rand_q15(), rand_q15());

    set_window(8'd255);
    rand_phase(110);
    set_window(8'd1);
    rand_phase(100);
    set_window(8'd2);
    rand_phase(80);
    set_window(TAPS_RESET);
    rand_phase(100);
    set_window(8'd17);
    rand_phase(80);
    set_window(8'd129);
    rand_phase(50);
    set_window(8'($urandom));
    rand_phase(50);

    wait_idle();
    repeat (MAX_TAPS + 16) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
